>>> hdl/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg
// shared types and constants of the sound chip register and buffer unit
// ----------------------------------------------------------------------------
package scr_pkg;

    localparam int BUF_BYTES  = 2048;
    localparam int BUF_AW     = $clog2(BUF_BYTES);
    localparam int HALF_AW    = BUF_AW - 1;

    // register window indexes, 0x800 upwards
    localparam logic [2:0] REG_VERSION = 3'd0;
    localparam logic [2:0] REG_MODE    = 3'd1;
    localparam logic [2:0] REG_CHANNEL = 3'd2;
    localparam logic [2:0] REG_FIFO    = 3'd3;
    localparam logic [2:0] REG_IRQ     = 3'd4;
    localparam logic [2:0] REG_MISC    = 3'd5;
    localparam logic [2:0] REG_VOLUME  = 3'd6;
    localparam logic [2:0] REG_CLOCK   = 3'd7;

    localparam logic [12:0] REG_PAGE   = 13'h100;

    localparam logic [1:0] MODE_PCM    = 2'd1;

    localparam logic [7:0] MASK_MODE    = 8'h03;
    localparam logic [7:0] MASK_CHANNEL = 8'h83;
    localparam logic [7:0] MASK_FIFO    = 8'h83;
    localparam logic [7:0] MASK_MISC    = 8'h8f;
    localparam logic [7:0] MASK_VOLUME  = 8'hfc;
    localparam logic [7:0] MASK_CLOCK   = 8'h03;
    localparam logic [7:0] IRQ_STATUS   = 8'hff;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr_wr;
        logic wr_byte;
        logic rd_issue;
        logic rd_capture;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_write;
        logic in_size_zero;
        logic cnt_last;
        logic clr_last;
        logic out_free;
    } t_status;

endpackage

>>> hdl/scr_ram.sv
// ----------------------------------------------------------------------------
// scr_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module scr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/scr_ctrl.sv
// ----------------------------------------------------------------------------
// scr_ctrl
// sequencer: buffer clearing pass, then one byte operation per step
// ----------------------------------------------------------------------------
module scr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  scr_pkg::t_status i_status,
    output scr_pkg::t_cmd    o_cmd
);

    import scr_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_RISSUE = 3'd3;
    localparam logic [2:0] S_RCAP   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.in_size_zero) begin
                        n_state = S_DONE;
                    end else if (i_status.in_write) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_RISSUE;
                    end
                end
            end
            S_WRITE: begin
                o_cmd.wr_byte = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_RISSUE: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_RCAP;
            end
            S_RCAP: begin
                o_cmd.rd_capture = 1'b1;
                n_state = i_status.cnt_last ? S_DONE : S_RISSUE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/scr_datapath.sv
// ----------------------------------------------------------------------------
// scr_datapath
// sample buffer, ring pointers, byte registers and result assembly
// ----------------------------------------------------------------------------
module scr_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  scr_pkg::t_cmd    i_cmd,
    output scr_pkg::t_status o_status,
    input  logic             i_command,
    input  logic [15:0]      i_address,
    input  logic [2:0]       i_size,
    input  logic [31:0]      i_write_data,
    input  logic             i_cfg_valid,
    input  logic [7:0]       i_cfg_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [31:0]      o_read_data
);

    import scr_pkg::*;

    logic [15:0]        r_addr;
    logic [31:0]        r_data;
    logic [2:0]         r_cnt;
    logic               r_is_write;
    logic [31:0]        r_acc;
    logic [31:0]        r_out_data;
    logic               r_out_valid;
    logic [BUF_AW-1:0]  r_clr_addr;
    logic [BUF_AW-1:0]  r_left;
    logic [HALF_AW-1:0] r_right;
    logic [7:0]         r_version;
    logic [1:0]         r_mode;
    logic [7:0]         r_channel;
    logic [7:0]         r_fifo;
    logic [7:0]         r_misc;
    logic [7:0]         r_volume;
    logic [1:0]         r_clock;

    logic [2:0]         w_size_clamp;
    logic               w_in_buf;
    logic               w_in_reg;
    logic               w_pcm;
    logic               w_stereo;
    logic               w_upper;
    logic [7:0]         w_wbyte;
    logic [BUF_AW-1:0]  w_waddr;
    logic [BUF_AW-1:0]  w_raddr;
    logic [BUF_AW-1:0]  w_ram_addr;
    logic               w_ram_we;
    logic [7:0]         w_ram_wdata;
    logic [7:0]         w_ram_rdata;
    logic [7:0]         w_reg_rd;
    logic [7:0]         w_rbyte;

    assign w_size_clamp = i_size[2] ? 3'd4 : i_size;
    assign w_in_buf     = (r_addr[15:BUF_AW] == '0);
    assign w_in_reg     = (r_addr[15:3] == REG_PAGE);
    assign w_pcm        = (r_mode == MODE_PCM);
    assign w_stereo     = r_channel[1];
    assign w_upper      = r_addr[HALF_AW];
    assign w_wbyte      = r_data[{r_cnt[1:0] - 2'd1, 3'd0} +: 8];

    // pcm ring addressing: stereo splits the buffer into two halves
    always_comb begin
        if (w_pcm && w_stereo) begin
            w_waddr = w_upper ? {1'b1, r_right} : {1'b0, r_left[HALF_AW-1:0]};
            w_raddr = {1'b1, r_right};
        end else if (w_pcm) begin
            w_waddr = r_left;
            w_raddr = r_left;
        end else begin
            w_waddr = r_addr[BUF_AW-1:0];
            w_raddr = r_addr[BUF_AW-1:0];
        end
    end

    always_comb begin
        if (i_cmd.clr_wr) begin
            w_ram_addr  = r_clr_addr;
            w_ram_we    = 1'b1;
            w_ram_wdata = '0;
        end else if (i_cmd.wr_byte) begin
            w_ram_addr  = w_waddr;
            w_ram_we    = w_in_buf;
            w_ram_wdata = w_wbyte;
        end else begin
            w_ram_addr  = w_raddr;
            w_ram_we    = 1'b0;
            w_ram_wdata = w_wbyte;
        end
    end

    scr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        case (r_addr[2:0])
            REG_VERSION: w_reg_rd = r_version;
            REG_MODE:    w_reg_rd = {6'd0, r_mode};
            REG_CHANNEL: w_reg_rd = r_channel;
            REG_FIFO:    w_reg_rd = r_fifo;
            REG_IRQ:     w_reg_rd = IRQ_STATUS;
            REG_MISC:    w_reg_rd = r_misc;
            REG_VOLUME:  w_reg_rd = r_volume;
            REG_CLOCK:   w_reg_rd = {6'd0, r_clock};
            default:     w_reg_rd = '0;
        endcase
    end

    always_comb begin
        if (w_in_buf) begin
            w_rbyte = w_ram_rdata;
        end else if (w_in_reg) begin
            w_rbyte = w_reg_rd;
        end else begin
            w_rbyte = '0;
        end
    end

    // access sequencing
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr     <= i_address;
            r_data     <= i_write_data;
            r_cnt      <= w_size_clamp;
            r_is_write <= i_command;
            r_acc      <= '0;
        end else if (i_cmd.wr_byte) begin
            r_cnt <= r_cnt - 3'd1;
        end else if (i_cmd.rd_capture) begin
            r_cnt  <= r_cnt - 3'd1;
            r_addr <= r_addr + 16'd1;
            r_acc  <= {r_acc[23:0], w_rbyte};
        end
        if (i_cmd.finish) begin
            r_out_data <= r_acc;
        end
    end

    // control and chip state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_clr_addr  <= '0;
            r_left      <= '0;
            r_right     <= '0;
            r_version   <= '0;
            r_mode      <= '0;
            r_channel   <= '0;
            r_fifo      <= '0;
            r_misc      <= '0;
            r_volume    <= '0;
            r_clock     <= '0;
        end else begin
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_valid) begin
                r_version <= i_cfg_data;
            end
            if (i_cmd.wr_byte && w_in_buf && w_pcm) begin
                if (w_stereo && w_upper) begin
                    r_right <= r_right + 1'b1;
                end else begin
                    r_left <= r_left + 1'b1;
                end
            end
            if (i_cmd.wr_byte && w_in_reg) begin
                case (r_addr[2:0])
                    REG_MODE:    r_mode    <= w_wbyte[1:0] & MASK_MODE[1:0];
                    REG_CHANNEL: r_channel <= w_wbyte & MASK_CHANNEL;
                    REG_FIFO:    r_fifo    <= w_wbyte & MASK_FIFO;
                    REG_MISC:    r_misc    <= w_wbyte & MASK_MISC;
                    REG_VOLUME:  r_volume  <= w_wbyte & MASK_VOLUME;
                    REG_CLOCK:   r_clock   <= w_wbyte[1:0] & MASK_CLOCK[1:0];
                    default:     r_mode    <= r_mode;
                endcase
            end
        end
    end

    assign o_status.in_write     = i_command;
    assign o_status.in_size_zero = (i_size == 3'd0);
    assign o_status.cnt_last     = (r_cnt == 3'd1);
    assign o_status.clr_last     = &r_clr_addr;
    assign o_status.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clr_wr, i_cmd.wr_byte, i_cmd.rd_issue, i_cmd.rd_capture}))
        else $error("more than one buffer operation in a cycle");

    a_cap_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_capture |-> $past(i_cmd.rd_issue))
        else $error("read capture without a preceding issue");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_is_write) |-> (r_acc == '0))
        else $error("write access produced read data");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

endmodule

>>> hdl/sound_chip_register_and_fifo.sv
// ----------------------------------------------------------------------------
// sound_chip_register_and_fifo
// bus access unit: 2048-byte sample buffer and eight byte registers
// ----------------------------------------------------------------------------
// sequence: a write runs one write state per byte, a read an issue and a
//   capture state per byte, size zero neither; then done sets o_out_valid
// access: one at a time; done waits until the result register is free,
//   and read bytes need issue and capture on the ram
// reset: synchronous, active low; then a clearing pass zeroes the buffer,
//   with no input beat taken meanwhile (config writes still taken)
// ----------------------------------------------------------------------------
module sound_chip_register_and_fifo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // access channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [15:0] i_address,
    input  logic [2:0]  i_size,
    input  logic [31:0] i_write_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    // version register write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    import scr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // the version register takes a beat in any cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: clearing pass, then one byte step per state
    scr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // buffer, pointers, registers and the result register that parts
    // the access channel from the result channel
    scr_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_command    (i_command),
        .i_address    (i_address),
        .i_size       (i_size),
        .i_write_data (i_write_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_data  (o_read_data)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the sound chip bus access unit beat by beat against a behavioural
// model of its buffer, ring pointers and byte registers, through directed
// accesses and several random phases under changing version register values
// ----------------------------------------------------------------------------
module testbench;
    import scr_pkg::*;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam int CLK_HALF_NS   = 5;
    localparam int RESET_CYCLES  = 4;
    // settle time covers the longest access, a read of four bytes
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 200;
    localparam int TIMEOUT_NS    = 4_000_000;

    typedef enum {PHASE_GENERAL, PHASE_MONO, PHASE_STEREO} t_phase_kind;

    typedef struct packed {
        logic        command;
        logic [15:0] address;
        logic [2:0]  size;
        logic [31:0] write_data;
        logic [2:0]  gap;
    } t_bus_access;

    typedef struct packed {
        t_bus_access acc;
        logic [31:0] read_data;
    } t_read_expect;

    // clock, reset and block ports
    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic        i_command    = CMD_READ;
    logic [15:0] i_address    = '0;
    logic [2:0]  i_size       = '0;
    logic [31:0] i_write_data = '0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [31:0] o_read_data;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data   = '0;

    // model state of the unit
    logic [7:0]         sample_mem [0:BUF_BYTES-1];
    logic [BUF_AW-1:0]  model_left;
    logic [HALF_AW-1:0] model_right;
    logic [7:0]         version_q;
    logic [7:0]         mode_q;
    logic [7:0]         channel_q;
    logic [7:0]         fifo_q;
    logic [7:0]         misc_q;
    logic [7:0]         volume_q;
    logic [7:0]         clock_q;
    int                 left_wraps;
    int                 right_wraps;

    // stimulus and expectations
    t_bus_access  pending_accesses [$];
    t_read_expect expected_reads [$];
    logic [7:0]   version_writes [$];

    t_bus_access  cur_access;
    logic         access_loaded = 1'b0;
    int           access_wait;
    t_read_expect new_expect;
    t_read_expect oldest;
    logic [7:0]   cur_version;
    logic         version_loaded = 1'b0;
    int           result_wait;

    int accesses_sent;
    int results_checked;
    int versions_used;
    int error_count;

    sound_chip_register_and_fifo DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_address   (i_address),
        .i_size      (i_size),
        .i_write_data(i_write_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_read_data (o_read_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic logic [15:0] reg_addr(logic [2:0] idx);
        return {REG_PAGE, idx};
    endfunction

    // one byte read as the bus sees it
    function automatic logic [7:0] peek_byte(logic [15:0] addr);
        logic [7:0] value;
        value = 8'h00;
        if (addr < reg_addr(REG_VERSION)) begin
            if (mode_q != {6'd0, MODE_PCM}) begin
                value = sample_mem[addr[BUF_AW-1:0]];
            end else if (channel_q[1]) begin
                // stereo reads come from the right half
                value = sample_mem[{1'b1, model_right}];
            end else begin
                value = sample_mem[model_left];
            end
        end else if (addr[15:3] == REG_PAGE) begin
            case (addr[2:0])
                REG_VERSION: value = version_q;
                REG_MODE:    value = mode_q;
                REG_CHANNEL: value = channel_q;
                REG_FIFO:    value = fifo_q;
                REG_IRQ:     value = IRQ_STATUS;
                REG_MISC:    value = misc_q;
                REG_VOLUME:  value = volume_q;
                REG_CLOCK:   value = clock_q;
                default:     value = 8'h00;
            endcase
        end
        return value;
    endfunction

    // one byte written: ring append in pcm mode, masked register writes
    function automatic void poke_byte(logic [15:0] addr, logic [7:0] value);
        if (addr < reg_addr(REG_VERSION)) begin
            if (mode_q != {6'd0, MODE_PCM}) begin
                sample_mem[addr[BUF_AW-1:0]] = value;
            end else if (channel_q[1] && addr[HALF_AW]) begin
                sample_mem[{1'b1, model_right}] = value;
                model_right = model_right + 1'b1;
                if (model_right == '0) right_wraps++;
            end else begin
                // mono uses the whole pointer, stereo left only its low half
                if (channel_q[1]) sample_mem[{1'b0, model_left[HALF_AW-1:0]}] = value;
                else sample_mem[model_left] = value;
                model_left = model_left + 1'b1;
                if (model_left == '0) left_wraps++;
            end
        end else if (addr[15:3] == REG_PAGE) begin
            case (addr[2:0])
                REG_MODE:    mode_q    = value & MASK_MODE;
                REG_CHANNEL: channel_q = value & MASK_CHANNEL;
                REG_FIFO:    fifo_q    = value & MASK_FIFO;
                REG_MISC:    misc_q    = value & MASK_MISC;
                REG_VOLUME:  volume_q  = value & MASK_VOLUME;
                REG_CLOCK:   clock_q   = value & MASK_CLOCK;
                default: ;
            endcase
        end
    endfunction

    // whole access: writes repeat one address high byte first, reads walk up
    function automatic logic [31:0] run_bus_access(t_bus_access a);
        int          n;
        logic [31:0] rd;
        n  = (a.size > 3'd4) ? 4 : int'(a.size);
        rd = '0;
        if (a.command == CMD_WRITE) begin
            for (int k = n; k > 0; k--) poke_byte(a.address, a.write_data[(k-1)*8 +: 8]);
        end else begin
            for (int k = 0; k < n; k++) rd = {rd[23:0], peek_byte(a.address + 16'(k))};
        end
        return rd;
    endfunction

    task automatic push_access(logic cmd, logic [15:0] addr, logic [2:0] size,
                               logic [31:0] data);
        t_bus_access a;
        a.command    = cmd;
        a.address    = addr;
        a.size       = size;
        a.write_data = data;
        a.gap        = '0;
        pending_accesses.push_back(a);
    endtask

    // wait for every beat to come back, then let the block go quiet
    task automatic drain_and_settle();
        while (pending_accesses.size() != 0 || access_loaded || expected_reads.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_version(logic [7:0] value);
        version_writes.push_back(value);
        do @(negedge i_clk); while (version_writes.size() != 0 || version_loaded);
        versions_used++;
    endtask

    task automatic random_phase(t_phase_kind kind, int count);
        t_bus_access a;
        int          pick;
        int          size_pick;
        logic        focused;
        focused = (kind != PHASE_GENERAL);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (focused) a.command = ($urandom_range(0, 99) < 85) ? CMD_WRITE : CMD_READ;
            else a.command = 1'($urandom_range(0, 1));
            if (pick < (focused ? 90 : 45)) begin
                // buffer traffic; stereo leans on the right half
                if (kind == PHASE_STEREO && $urandom_range(0, 99) < 80)
                    a.address = 16'($urandom_range(16'h0400, 16'h07ff));
                else if (kind == PHASE_STEREO)
                    a.address = 16'($urandom_range(16'h0000, 16'h03ff));
                else
                    a.address = 16'($urandom_range(16'h0000, 16'h07ff));
            end else if (pick < (focused ? 95 : 70)) begin
                a.address = reg_addr(3'($urandom_range(0, 7)));
            end else if (!focused && pick < 80) begin
                // boundaries of the halves, the buffer top and the address space
                case ($urandom_range(0, 7))
                    0: a.address = 16'h03ff;
                    1: a.address = 16'h0400;
                    2: a.address = 16'h07fd;
                    3: a.address = 16'h07fe;
                    4: a.address = 16'h07ff;
                    5: a.address = 16'h0808;
                    6: a.address = 16'hfffd;
                    default: a.address = 16'hffff;
                endcase
            end else begin
                a.address = 16'($urandom_range(0, 16'hffff));
            end
            // focused phases keep their mode and channel setting
            if (focused && a.command == CMD_WRITE &&
                (a.address == reg_addr(REG_MODE) || a.address == reg_addr(REG_CHANNEL)))
                a.command = CMD_READ;
            size_pick = $urandom_range(0, 19);
            if (focused && size_pick < 14) a.size = 3'd4;
            else if (size_pick == 0) a.size = 3'd0;
            else if (size_pick == 1) a.size = 3'($urandom_range(5, 7));
            else a.size = 3'($urandom_range(1, 4));
            a.write_data = $urandom;
            // every third run of forty goes back to back
            a.gap = ((i / 40) % 3 == 0) ? 3'd0 : 3'($urandom_range(0, 4));
            pending_accesses.push_back(a);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    // access driver: waits out each beat's gap, then holds the beat until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid    <= 1'b0;
            access_loaded = 1'b0;
            access_wait   = 0;
            cur_access    = '0;
        end else begin
            if (access_loaded && i_in_valid && o_in_ready) begin
                new_expect.acc       = cur_access;
                new_expect.read_data = run_bus_access(cur_access);
                expected_reads.push_back(new_expect);
                accesses_sent++;
                access_loaded = 1'b0;
            end
            if (!access_loaded && pending_accesses.size() != 0) begin
                if (access_wait < pending_accesses[0].gap) begin
                    access_wait++;
                end else begin
                    cur_access    = pending_accesses.pop_front();
                    access_loaded = 1'b1;
                    access_wait   = 0;
                end
            end
            i_in_valid   <= access_loaded;
            i_command    <= cur_access.command;
            i_address    <= cur_access.address;
            i_size       <= cur_access.size;
            i_write_data <= cur_access.write_data;
        end
    end

    // version register driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid    <= 1'b0;
            version_loaded = 1'b0;
            cur_version    = '0;
        end else begin
            if (version_loaded && i_cfg_valid && o_cfg_ready) begin
                version_q      = cur_version;
                version_loaded = 1'b0;
            end
            if (!version_loaded && version_writes.size() != 0) begin
                cur_version    = version_writes.pop_front();
                version_loaded = 1'b1;
            end
            i_cfg_valid <= version_loaded;
            i_cfg_data  <= cur_version;
        end
    end

    // result monitor: random stalls, runs of none, and two long hold-offs
    // during which the sender keeps offering beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            result_wait = 0;
        end else begin
            if (i_out_ready && o_out_valid) begin
                if (expected_reads.size() == 0) begin
                    $display("%0t: result with nothing outstanding, expected none, got 0x%08h",
                             $time, o_read_data);
                    error_count++;
                end else begin
                    oldest = expected_reads.pop_front();
                    if (o_read_data !== oldest.read_data) begin
                        $display("%0t: cmd %0d addr 0x%04h size %0d, expected 0x%08h, got 0x%08h",
                                 $time, oldest.acc.command, oldest.acc.address,
                                 oldest.acc.size, oldest.read_data, o_read_data);
                        error_count++;
                    end
                end
                results_checked++;
                if (results_checked == 400 || results_checked == 1200)
                    result_wait = LONG_HOLD;
                else if ((results_checked / 50) % 3 == 1)
                    result_wait = 0;
                else
                    result_wait = $urandom_range(0, 4);
            end else if (result_wait > 0) begin
                result_wait--;
            end
            i_out_ready <= (result_wait == 0);
        end
    end

    initial begin
        // model matches the state after reset and the clearing pass
        for (int i = 0; i < BUF_BYTES; i++) sample_mem[i] = 8'h00;
        model_left      = '0;
        model_right     = '0;
        version_q       = '0;
        mode_q          = '0;
        channel_q       = '0;
        fifo_q          = '0;
        misc_q          = '0;
        volume_q        = '0;
        clock_q         = '0;
        left_wraps      = 0;
        right_wraps     = 0;
        accesses_sent   = 0;
        results_checked = 0;
        versions_used   = 0;
        error_count     = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part
        set_version(8'h5a);
        push_access(CMD_READ,  reg_addr(REG_VERSION), 3'd1, 32'h0);
        push_access(CMD_READ,  reg_addr(REG_MODE),    3'd4, 32'h0);
        // mode three is kept and behaves as random access
        push_access(CMD_WRITE, reg_addr(REG_MODE),    3'd1, 32'hff);
        push_access(CMD_WRITE, reg_addr(REG_CHANNEL), 3'd4, 32'hffff_ffff);
        push_access(CMD_WRITE, reg_addr(REG_FIFO),    3'd2, 32'h0000_00ff);
        // read-only registers ignore writes
        push_access(CMD_WRITE, reg_addr(REG_IRQ),     3'd1, 32'h0);
        push_access(CMD_WRITE, reg_addr(REG_MISC),    3'd1, 32'hff);
        push_access(CMD_WRITE, reg_addr(REG_VOLUME),  3'd1, 32'hff);
        push_access(CMD_WRITE, reg_addr(REG_CLOCK),   3'd3, 32'h0000_00ff);
        push_access(CMD_WRITE, reg_addr(REG_VERSION), 3'd1, 32'h0);
        push_access(CMD_READ,  reg_addr(REG_VERSION), 3'd4, 32'h0);
        push_access(CMD_READ,  reg_addr(REG_IRQ),     3'd4, 32'h0);
        // undecoded bytes, then the read address wraps to zero
        push_access(CMD_READ,  16'hfffe, 3'd4, 32'h0);
        push_access(CMD_WRITE, 16'h0000, 3'd4, 32'h1122_3344);
        push_access(CMD_WRITE, 16'h07ff, 3'd4, 32'hffff_ffff);
        // read running from the buffer top into the registers
        push_access(CMD_READ,  16'h07fe, 3'd4, 32'h0);
        // empty accesses, and an oversized one clipped to four bytes
        push_access(CMD_WRITE, 16'h0010, 3'd0, 32'hffff_ffff);
        push_access(CMD_READ,  16'h0000, 3'd0, 32'h0);
        push_access(CMD_READ,  16'h07fc, 3'd7, 32'h0);
        // pcm mono, then stereo ring appends
        push_access(CMD_WRITE, reg_addr(REG_MODE),    3'd1, 32'h01);
        push_access(CMD_WRITE, reg_addr(REG_CHANNEL), 3'd1, 32'h00);
        push_access(CMD_WRITE, 16'h0123, 3'd4, 32'hdead_beef);
        push_access(CMD_READ,  16'h0456, 3'd2, 32'h0);
        push_access(CMD_WRITE, reg_addr(REG_CHANNEL), 3'd1, 32'h02);
        push_access(CMD_WRITE, 16'h0100, 3'd2, 32'h0000_0102);
        push_access(CMD_WRITE, 16'h0700, 3'd2, 32'h0000_0304);
        push_access(CMD_READ,  16'h0000, 3'd1, 32'h0);
        push_access(CMD_WRITE, reg_addr(REG_MODE),    3'd1, 32'h00);
        push_access(CMD_READ,  16'h0400, 3'd4, 32'h0);
        drain_and_settle();

        // random phases, version register changed only while idle
        set_version(8'hff);
        random_phase(PHASE_GENERAL, 300);
        drain_and_settle();

        set_version(8'($urandom_range(0, 255)));
        push_access(CMD_WRITE, reg_addr(REG_MODE),    3'd1, ($urandom & 32'hffff_fffc) | 32'h1);
        push_access(CMD_WRITE, reg_addr(REG_CHANNEL), 3'd1, $urandom & 32'hffff_fffd);
        random_phase(PHASE_MONO, 700);
        drain_and_settle();

        set_version(8'h00);
        push_access(CMD_WRITE, reg_addr(REG_CHANNEL), 3'd1, $urandom | 32'h2);
        random_phase(PHASE_STEREO, 600);
        drain_and_settle();

        set_version(8'($urandom_range(0, 255)));
        random_phase(PHASE_GENERAL, 300);
        drain_and_settle();

        $display("summary: %0d accesses, %0d results checked, %0d version settings",
                 accesses_sent, results_checked, versions_used);
        $display("summary: pcm pointer wraps, left %0d, right %0d", left_wraps, right_wraps);
        if (error_count == 0 && expected_reads.size() == 0) begin
            $display("sound_chip_register_and_fifo test passed");
        end else begin
            $display("sound_chip_register_and_fifo test failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout, %0d results still outstanding", $time, expected_reads.size());
        $display("sound_chip_register_and_fifo test failed");
        $finish;
    end

endmodule

>>> files.f
hdl/scr_pkg.sv
hdl/scr_ram.sv
hdl/scr_ctrl.sv
hdl/scr_datapath.sv
hdl/sound_chip_register_and_fifo.sv
tb/testbench.sv
